// File: design/drd_pkg.sv
// Package for the dictionary run decoder: item types, result kind codes,
// table depth and derived widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int VALUE_W     = 64;

    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_RUN      = 3'd1;
    localparam logic [2:0] KIND_COUNT    = 3'd2;
    localparam logic [2:0] KIND_BADVAR   = 3'd3;
    localparam logic [2:0] KIND_BADINDEX = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
    } drd_in_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [VALUE_W-1:0] value;
    } drd_out_t;

endpackage

`default_nettype wire

// File: design/drd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module drd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/dictionary_run_decoder.sv
// Top level of the dictionary run decoder: varint parser, table control,
// result pipeline. Depends on drd_pkg and drd_ram.
//
// Usage:
//   src channel takes one stream byte per item; block_start marks the
//   table-size byte of a new block. res channel gives result items
//   (data value, run length, element count or an error kind).
//   A byte that yields a result passes the read stage, where the value
//   table is read, and then the output register before it shows on res.
//   One byte is taken every cycle while res is ready; each byte
//   does at most one access to the single value table RAM.
//   Table varints are written at the byte that ends them; data bytes read
//   the table, and the result carries the registered read data.
//   Reset puts the decoder in the state that waits for a block start and
//   empties the result pipeline; table contents stay undefined until the
//   block loads them, which it always does before any data byte reads.
//   When res stalls, the output register holds its item, one more result
//   waits in the read stage, and then src_ready drops until res drains.
//   After an error, bytes are dropped until the next block start.
`timescale 1ns / 1ps
`default_nettype none

module dictionary_run_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire drd_pkg::drd_in_t  src_item,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output drd_pkg::drd_out_t      res_item
);

    import drd_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TABLE = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_ERROR = 3'd4;

    localparam logic [3:0] LAST_VBYTE = 4'd9;

    logic [2:0]         phase_reg, phase_next;
    logic [7:0]         expected_reg, expected_next;
    logic [7:0]         loaded_reg, loaded_next;
    logic [63:0]        acc_reg, acc_next;
    logic [3:0]         vcount_reg, vcount_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [2:0]         s1_kind_reg;
    logic [63:0]        s1_value_reg;
    logic               s1_mem_reg;
    logic               out_valid_reg, out_valid_next;
    drd_out_t           out_reg;

    logic               accept;
    logic               s1_advance;
    logic [7:0]         in_byte;
    logic [6:0]         bits;
    logic               cont;
    logic               last_vbyte;
    logic               overflow;
    logic               vdone;
    logic [6:0]         shamt;
    logic [63:0]        acc_new;
    logic [7:0]         loaded_inc;
    logic [6:0]         idx;

    logic               emit;
    logic [2:0]         emit_kind;
    logic [63:0]        emit_value;
    logic               emit_mem;

    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [63:0]        ram_rdata;

    assign s1_advance = !out_valid_reg || res_ready;
    assign src_ready  = !s1_valid_reg || s1_advance;
    assign accept     = src_valid && src_ready;

    assign in_byte    = src_item.data_byte;
    assign bits       = in_byte[6:0];
    assign cont       = in_byte[7];
    assign idx        = in_byte[6:0];
    assign last_vbyte = vcount_reg >= LAST_VBYTE;
    assign overflow   = last_vbyte && ((bits > 7'd1) || cont);
    assign vdone      = last_vbyte || !cont;
    assign shamt      = 7'(vcount_reg) * 7'd7;
    assign acc_new    = last_vbyte ? (acc_reg | {bits[0], 63'd0})
                                   : (acc_reg | ({57'd0, bits} << shamt));
    assign loaded_inc = 8'(loaded_reg + 8'd1);

    assign ram_waddr  = ADDR_W'(loaded_reg);
    assign ram_raddr  = ADDR_W'(idx);

    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        loaded_next   = loaded_reg;
        acc_next      = acc_reg;
        vcount_next   = vcount_reg;
        emit          = 1'b0;
        emit_kind     = KIND_DATA;
        emit_value    = '0;
        emit_mem      = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (accept)
        begin
            if (src_item.block_start)
            begin
                acc_next    = '0;
                vcount_next = '0;
                loaded_next = '0;
                if ({1'b0, in_byte} > 9'(TABLE_DEPTH))
                begin
                    expected_next = '0;
                    phase_next    = PH_ERROR;
                    emit          = 1'b1;
                    emit_kind     = KIND_BADVAR;
                end
                else
                begin
                    expected_next = in_byte;
                    phase_next    = (in_byte == 8'd0) ? PH_COUNT : PH_TABLE;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_TABLE, PH_COUNT:
                    begin
                        if (overflow)
                        begin
                            acc_next    = '0;
                            vcount_next = '0;
                            phase_next  = PH_ERROR;
                            emit        = 1'b1;
                            emit_kind   = KIND_BADVAR;
                        end
                        else if (!vdone)
                        begin
                            acc_next    = acc_new;
                            vcount_next = 4'(vcount_reg + 4'd1);
                        end
                        else if (phase_reg == PH_TABLE)
                        begin
                            ram_we      = {1'b0, loaded_reg} < 9'(TABLE_DEPTH);
                            loaded_next = loaded_inc;
                            acc_next    = '0;
                            vcount_next = '0;
                            if (loaded_inc >= expected_reg)
                            begin
                                phase_next = PH_COUNT;
                            end
                        end
                        else
                        begin
                            acc_next    = '0;
                            vcount_next = '0;
                            phase_next  = PH_DATA;
                            emit        = 1'b1;
                            emit_kind   = KIND_COUNT;
                            emit_value  = acc_new;
                        end
                    end
                    PH_DATA:
                    begin
                        emit = 1'b1;
                        if ({1'b0, idx} >= expected_reg)
                        begin
                            phase_next = PH_ERROR;
                            emit_kind  = KIND_BADINDEX;
                        end
                        else
                        begin
                            emit_kind = cont ? KIND_RUN : KIND_DATA;
                            emit_mem  = 1'b1;
                            ram_re    = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (src_ready)
        begin
            s1_valid_next = accept && emit;
        end
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            expected_reg  <= '0;
            loaded_reg    <= '0;
            acc_reg       <= '0;
            vcount_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            expected_reg  <= expected_next;
            loaded_reg    <= loaded_next;
            acc_reg       <= acc_next;
            vcount_reg    <= vcount_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_kind_reg  <= emit_kind;
            s1_value_reg <= emit_value;
            s1_mem_reg   <= emit_mem;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_reg.kind  <= s1_kind_reg;
            out_reg.value <= s1_mem_reg ? ram_rdata : s1_value_reg;
        end
    end

    drd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (acc_new),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

endmodule

`default_nettype wire

// File: design/drd_checker.sv
// Port-level checks for dictionary_run_decoder, attached by bind.
// Depends on drd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drd_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    input  wire logic              src_ready,
    input  wire drd_pkg::drd_in_t  src_item,
    input  wire logic              res_valid,
    input  wire logic              res_ready,
    input  wire drd_pkg::drd_out_t res_item
);

    import drd_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.kind <= KIND_BADINDEX)
        else $error("result kind out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.kind == KIND_BADVAR || res_item.kind == KIND_BADINDEX)
        |-> res_item.value == '0)
        else $error("error item with nonzero value");

    a_start_no_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready && src_item.block_start && res_valid && !res_ready
        |=> !(src_valid && src_ready) || !res_valid || res_ready
            || res_item.kind != KIND_BADINDEX || $stable(res_item))
        else $error("stalled result replaced after block start");

endmodule

bind dictionary_run_decoder drd_checker u_drd_checker (.*);

`default_nettype wire

// File: tb/dictionary_run_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench for dictionary_run_decoder: directed and random compressed streams
// through a bursty driver and a stalling monitor, checked against an in-line decoder.
// Depends on drd_pkg and the design files.

module dictionary_run_decoder_tb;
    import drd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1650;
    localparam int SETTLE_TICKS = 10;

    typedef enum logic [2:0] {AWAIT_START, LOAD_TABLE, LOAD_COUNT, DECODE, HALTED} dec_phase_t;

    typedef struct {
        logic    drain_first;
        drd_in_t item;
    } pending_byte_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_ready;
    drd_in_t  src_item  = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    drd_out_t res_item;

    pending_byte_t byte_queue[$];
    drd_out_t      expected_results[$];
    drd_out_t      want_result;
    logic          drain_next     = 1'b0;
    int unsigned   total_bytes    = 0;
    int unsigned   bytes_accepted = 0;
    int unsigned   mismatches     = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   gap_left       = 0;
    int unsigned   burst_left     = 0;
    int unsigned   stall_tick     = 0;
    int unsigned   stall_mode     = 0;

    dec_phase_t         dec_phase      = AWAIT_START;
    int unsigned        dec_table_size = 0;
    int unsigned        dec_loaded     = 0;
    int unsigned        dec_vbytes     = 0;
    logic [VALUE_W-1:0] dec_acc        = '0;
    logic [VALUE_W-1:0] dec_table [TABLE_DEPTH];

    dictionary_run_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic decode_byte(input drd_in_t it);
        drd_out_t   r;
        logic [6:0] grp;
        logic       done;
        logic       bad;
        grp  = it.data_byte[6:0];
        done = 1'b0;
        bad  = 1'b0;
        if (it.block_start)
        begin
            dec_acc    = '0;
            dec_vbytes = 0;
            dec_loaded = 0;
            if (it.data_byte > TABLE_DEPTH)
            begin
                dec_table_size = 0;
                dec_phase      = HALTED;
                r.kind  = KIND_BADVAR;
                r.value = '0;
                expected_results.insert(expected_results.size(), r);
            end
            else
            begin
                dec_table_size = it.data_byte;
                dec_phase      = (it.data_byte == 8'd0) ? LOAD_COUNT : LOAD_TABLE;
            end
        end
        else if (dec_phase == LOAD_TABLE || dec_phase == LOAD_COUNT)
        begin
            if (dec_vbytes >= 9)
            begin
                bad = (grp > 7'd1) || it.data_byte[7];
                dec_acc[VALUE_W-1] = dec_acc[VALUE_W-1] | grp[0];
                dec_vbytes = 10;
                done = !bad;
            end
            else
            begin
                dec_acc    = dec_acc | (VALUE_W'(grp) << (7 * dec_vbytes));
                dec_vbytes = dec_vbytes + 1;
                done       = !it.data_byte[7];
            end
            if (bad)
            begin
                dec_acc    = '0;
                dec_vbytes = 0;
                dec_phase  = HALTED;
                r.kind  = KIND_BADVAR;
                r.value = '0;
                expected_results.insert(expected_results.size(), r);
            end
            else if (done && dec_phase == LOAD_TABLE)
            begin
                if (dec_loaded < TABLE_DEPTH)
                    dec_table[dec_loaded] = dec_acc;
                dec_loaded = (dec_loaded + 1) & 32'hFF;
                dec_acc    = '0;
                dec_vbytes = 0;
                if (dec_loaded >= dec_table_size)
                    dec_phase = LOAD_COUNT;
            end
            else if (done)
            begin
                r.kind  = KIND_COUNT;
                r.value = dec_acc;
                expected_results.insert(expected_results.size(), r);
                dec_acc    = '0;
                dec_vbytes = 0;
                dec_phase  = DECODE;
            end
        end
        else if (dec_phase == DECODE)
        begin
            if (grp >= dec_table_size)
            begin
                dec_phase = HALTED;
                r.kind  = KIND_BADINDEX;
                r.value = '0;
            end
            else
            begin
                r.kind  = it.data_byte[7] ? KIND_RUN : KIND_DATA;
                r.value = dec_table[grp];
            end
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    task automatic put_byte(input logic [7:0] b, input logic start);
        pending_byte_t p;
        p.drain_first     = drain_next;
        p.item.data_byte  = b;
        p.item.block_start = start;
        drain_next = 1'b0;
        byte_queue.insert(byte_queue.size(), p);
    endtask

    task automatic put_varint(input logic [VALUE_W-1:0] v, input int unsigned pad);
        logic [VALUE_W-1:0] rest;
        int unsigned        nbytes;
        int unsigned        n;
        nbytes = 1;
        for (rest = v >> 7; rest != '0; rest = rest >> 7)
            nbytes++;
        nbytes = (nbytes + pad > 10) ? 10 : nbytes + pad;
        rest = v;
        for (n = 0; n < nbytes; n++)
        begin
            put_byte({n != nbytes - 1, rest[6:0]}, 1'b0);
            rest = rest >> 7;
        end
    endtask

    task automatic put_noise();
        int unsigned n;
        for (n = $urandom_range(0, 3); n > 0; n--)
            put_byte(8'($urandom), 1'b0);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        int unsigned        len;
        logic [VALUE_W-1:0] v;
        len = $urandom_range(0, 64);
        v   = {$urandom, $urandom};
        if (len < 64)
            v = v & ((64'd1 << len) - 64'd1);
        return v;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_item  <= '0;
        end
        else
        begin
            if (src_valid && src_ready)
            begin
                decode_byte(src_item);
                bytes_accepted = bytes_accepted + 1;
            end
            if (!src_valid || src_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    src_valid <= 1'b0;
                end
                else if (byte_queue.size() == 0)
                    src_valid <= 1'b0;
                else if (byte_queue[0].drain_first && expected_results.size() != 0)
                    src_valid <= 1'b0;
                else
                begin
                    src_valid <= 1'b1;
                    src_item  <= byte_queue[0].item;
                    byte_queue.pop_front();
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(100, 300);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 30);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                    else
                        burst_left = burst_left - 1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d value %h",
                                 res_item.kind, res_item.value);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (res_item.kind !== want_result.kind ||
                        res_item.value !== want_result.value)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: kind exp %0d got %0d, value exp %h got %h",
                                     want_result.kind, res_item.kind,
                                     want_result.value, res_item.value);
                    end
                end
            end
            stall_tick = stall_tick + 1;
            if (stall_tick % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= 1'($urandom);
                2: res_ready <= ($urandom_range(0, 9) == 0);
                default: res_ready <= (stall_tick % 7) < 4;
            endcase
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[dictionary_run_decoder] ERROR");
        $finish;
    end

    initial
    begin
        int unsigned size;
        int unsigned nd;
        int unsigned k;
        int unsigned i;
        logic        broken;
        logic [7:0]  idx;

        // ignored before any block start
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        // two entries: zero with a trailing zero group, then all ones
        put_byte(8'd2, 1'b1);
        put_byte(8'h80, 1'b0);
        put_byte(8'h00, 1'b0);
        put_varint({VALUE_W{1'b1}}, 0);
        put_byte(8'h03, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h81, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(8'h12, 1'b0);
        // oversized tables
        put_byte(8'd255, 1'b1);
        put_byte(8'd129, 1'b1);
        // empty table: count, then any index is out of range
        put_byte(8'd0, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);

        drain_next = 1'b1;
        while (byte_queue.size() < ITEM_TARGET)
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
                size = $urandom_range(TABLE_DEPTH + 1, 255);
            else if (k < 8)
                size = 0;
            else if (k < 10)
                size = TABLE_DEPTH;
            else if (k < 20)
                size = $urandom_range(9, TABLE_DEPTH - 1);
            else
                size = $urandom_range(1, 8);
            if ($urandom_range(0, 7) == 0)
                drain_next = 1'b1;
            put_byte(8'(size), 1'b1);
            if (size > TABLE_DEPTH)
            begin
                put_noise();
                continue;
            end
            broken = 1'b0;
            for (i = 0; i <= size && !broken; i++)
            begin
                k = $urandom_range(0, 59);
                if (k == 0)
                begin
                    for (nd = 0; nd < 9; nd++)
                        put_byte({1'b1, 7'($urandom)}, 1'b0);
                    if ($urandom_range(0, 1) == 0)
                        put_byte({1'b0, 7'($urandom_range(2, 127))}, 1'b0);
                    else
                        put_byte({1'b1, 7'($urandom)}, 1'b0);
                    broken = 1'b1;
                end
                else if (k == 1 && i < size)
                begin
                    if ($urandom_range(0, 1) == 0)
                        put_byte({1'b1, 7'($urandom)}, 1'b0);
                    broken = 1'b1;
                end
                else
                    put_varint(rand_value(),
                               ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
            end
            if (broken)
            begin
                put_noise();
                continue;
            end
            nd = (size == 0) ? 1 : $urandom_range(4, 40);
            for (i = 0; i < nd; i++)
            begin
                if (size != 0 && (size == TABLE_DEPTH || $urandom_range(0, 49) != 0))
                    idx = 8'($urandom_range(0, size - 1));
                else
                    idx = 8'($urandom_range(size, 127));
                put_byte({1'($urandom), idx[6:0]}, 1'b0);
                if (idx >= size)
                begin
                    put_noise();
                    break;
                end
            end
        end
        total_bytes = byte_queue.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted < total_bytes)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        mismatches = mismatches + expected_results.size();
        if (mismatches == 0)
            $display("[dictionary_run_decoder] OK");
        else
            $display("[dictionary_run_decoder] ERROR");
        $finish;
    end

endmodule
